// ===== src/via64_pkg.sv =====
`timescale 1ns / 1ps
package via64_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned KindWidth = 4;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_MOD = 4'd4,
      OP_AND = 4'd5,
      OP_OR  = 4'd6,
      OP_XOR = 4'd7,
      OP_NOT = 4'd8,
      OP_SHL = 4'd9,
      OP_SHR = 4'd10
   } op_type;

   // one pipeline slot carried between stages
   typedef struct packed {
      logic                 valid;
      logic [3:0]           kind;
      logic [63:0]          result;
      logic                 write_back;
      logic                 divide_by_zero;
   } slot_type;

endpackage

// ===== src/vm_integer_alu_64.sv =====
`timescale 1ns / 1ps
// Unsigned 64-bit VM ALU. A request is taken whenever start is high (busy is
// always low) and exactly one result appears with rsp_valid after one input
// register, the divider (16 stages by default) and an output register. Every
// operation takes the same path length, so results leave in request order,
// one per cycle at full rate. The receiver cannot stall; nothing is held back.
module vm_integer_alu_64 #(
   parameter int unsigned DivStages = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_kind,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   output logic        rsp_valid,
   output logic [63:0] rsp_result,
   output logic        rsp_write_back,
   output logic        rsp_divide_by_zero
);
   localparam int unsigned Depth = DivStages + 1;

   logic        v_ff;
   logic [3:0]  k_ff;
   logic [63:0] a_ff, b_ff;

   via64_pkg::slot_type pipe_ff [Depth];
   via64_pkg::slot_type head_in;
   via64_pkg::slot_type out_ff, out_in;
   logic [63:0] mul_p, div_q, div_r;
   logic [63:0] mul_d_ff [DivStages-3];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else v_ff <= start;
      k_ff <= req_kind;
      a_ff <= req_operand_a;
      b_ff <= req_operand_b;
   end

   via64_mul u_mul (.clock(clock), .a(a_ff), .b(b_ff), .p(mul_p));
   via64_div #(.Stages(DivStages)) u_div (
      .clock(clock), .a(a_ff), .b(b_ff), .quo(div_q), .rem(div_r));

   // align the multiply result with the divider
   always_ff @(posedge clock) begin
      mul_d_ff[0] <= mul_p;
      for (int i = 1; i < DivStages - 3; i++) mul_d_ff[i] <= mul_d_ff[i-1];
   end

   // simple ops computed up front, carried alongside
   always_comb begin
      head_in                = '0;
      head_in.valid          = v_ff;
      head_in.kind           = k_ff;
      head_in.write_back     = 1'b1;
      case (via64_pkg::op_type'(k_ff))
         via64_pkg::OP_ADD: head_in.result = a_ff + b_ff;
         via64_pkg::OP_SUB: head_in.result = a_ff - b_ff;
         via64_pkg::OP_AND: head_in.result = a_ff & b_ff;
         via64_pkg::OP_OR:  head_in.result = a_ff | b_ff;
         via64_pkg::OP_XOR: head_in.result = a_ff ^ b_ff;
         via64_pkg::OP_NOT: head_in.result = ~a_ff;
         via64_pkg::OP_SHL:
            head_in.result = (b_ff[63:6] != '0) ? '0 : a_ff << b_ff[5:0];
         via64_pkg::OP_SHR:
            head_in.result = (b_ff[63:6] != '0) ? '0 : a_ff >> b_ff[5:0];
         via64_pkg::OP_MUL: head_in.result = '0;
         via64_pkg::OP_DIV, via64_pkg::OP_MOD: begin
            if (b_ff == '0) begin
               head_in.write_back     = 1'b0;
               head_in.divide_by_zero = 1'b1;
            end
         end
         default: head_in.write_back = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) pipe_ff[0].valid <= 1'b0;
      else pipe_ff[0] <= head_in;
      for (int i = 1; i < Depth; i++) begin
         if (reset) pipe_ff[i].valid <= 1'b0;
         else pipe_ff[i] <= pipe_ff[i-1];
      end
   end

   always_comb begin
      out_in = pipe_ff[DivStages-1];
      case (via64_pkg::op_type'(out_in.kind))
         via64_pkg::OP_MUL: out_in.result = mul_d_ff[DivStages-4];
         via64_pkg::OP_DIV: if (!out_in.divide_by_zero) out_in.result = div_q;
         via64_pkg::OP_MOD: if (!out_in.divide_by_zero) out_in.result = div_r;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) out_ff.valid <= 1'b0;
      else out_ff <= out_in;
   end

   assign rsp_valid          = out_ff.valid;
   assign rsp_result         = out_ff.result;
   assign rsp_write_back     = out_ff.write_back;
   assign rsp_divide_by_zero = out_ff.divide_by_zero;

   // the last pipe slot only feeds the a_tail check below
   a_zero_flag_no_wb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> !rsp_write_back)
      else $error("divide by zero flagged with write back");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(DivStages + 2) rsp_valid)
      else $error("request did not produce a response in time");

   a_tail: assert property (@(posedge clock) disable iff (reset)
      pipe_ff[Depth-1].valid == $past(pipe_ff[DivStages-1].valid))
      else $error("pipe valid bits out of step");
endmodule

// ===== src/via64_mul.sv =====
`timescale 1ns / 1ps
// 64x64 low-half multiply over three stages: 32x32 partial products, then sum
module via64_mul (
   input  logic        clock,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] p
);
   logic [63:0] ll_ff, lh_ff, hl_ff;
   logic [31:0] cross_ff;
   logic [63:0] ll2_ff;
   logic [63:0] p_ff;
   logic [31:0] cross_in;

   assign cross_in = lh_ff[31:0] + hl_ff[31:0];

   always_ff @(posedge clock) begin
      ll_ff    <= a[31:0] * b[31:0];
      lh_ff    <= a[31:0] * b[63:32];
      hl_ff    <= a[63:32] * b[31:0];
      cross_ff <= cross_in;
      ll2_ff   <= ll_ff;
      p_ff     <= ll2_ff + {cross_ff, 32'd0};
   end

   assign p = p_ff;
endmodule

// ===== src/via64_div_stage.sv =====
`timescale 1ns / 1ps
// restoring divide, Bits quotient bits per stage
module via64_div_stage #(
   parameter int unsigned Bits = 2
) (
   input  logic        clock,
   input  logic [63:0] rem_i,
   input  logic [63:0] quo_i,
   input  logic [63:0] dvs_i,
   output logic [63:0] rem_o,
   output logic [63:0] quo_o,
   output logic [63:0] dvs_o
);
   logic [63:0] rem_in, quo_in;
   logic [64:0] r;
   logic [64:0] d;
   logic [63:0] rem_ff, quo_ff, dvs_ff;

   always_comb begin
      rem_in = rem_i;
      quo_in = quo_i;
      r      = '0;
      d      = {1'b0, dvs_i};
      for (int i = 0; i < Bits; i++) begin
         r      = {rem_in, quo_in[63]};
         quo_in = {quo_in[62:0], 1'b0};
         if (r >= d) begin
            r         = r - d;
            quo_in[0] = 1'b1;
         end
         rem_in = r[63:0];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_i;
   end

   assign rem_o = rem_ff;
   assign quo_o = quo_ff;
   assign dvs_o = dvs_ff;
endmodule

// ===== src/via64_div.sv =====
`timescale 1ns / 1ps
// pipelined divider: Stages stages of 64/Stages bits each
module via64_div #(
   parameter int unsigned Stages = 8
) (
   input  logic        clock,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] quo,
   output logic [63:0] rem
);
   localparam int unsigned Bits = 64 / Stages;

   logic [63:0] r_w [Stages+1];
   logic [63:0] q_w [Stages+1];
   logic [63:0] d_w [Stages+1];

   assign r_w[0] = '0;
   assign q_w[0] = a;
   assign d_w[0] = b;

   for (genvar s = 0; s < Stages; s++) begin : g_st
      via64_div_stage #(.Bits(Bits)) u_st (
         .clock(clock),
         .rem_i(r_w[s]), .quo_i(q_w[s]), .dvs_i(d_w[s]),
         .rem_o(r_w[s+1]), .quo_o(q_w[s+1]), .dvs_o(d_w[s+1])
      );
   end

   assign quo = q_w[Stages];
   assign rem = r_w[Stages];
endmodule
